// ===== src/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue package
// Sizes, codes and request types shared by the sorted timeout queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int DEPTH       = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int DELAY_W     = 37;
  localparam int TAG_W       = 16;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  typedef enum logic [1:0] {
    MODE_SCHEDULE = 2'd0,
    MODE_CANCEL   = 2'd1,
    MODE_EXPIRE   = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE_DUE  = 3'd5,
    ST_WAIT      = 3'd6,
    ST_EMPTY     = 3'd7
  } status_e;

  typedef struct packed {
    mode_e       mode;
    logic [47:0] now_us;
    logic [15:0] delay_s;
    logic [19:0] delay_us;
    logic [15:0] tag;
  } stq_req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_tag;
    logic [47:0] wait_us;
    logic        last;
  } stq_rsp_t;

endpackage

`default_nettype wire

// ===== src/sorted_timeout_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted timeout queue core
// Holds pending timeouts sorted by deadline and serves schedule, cancel,
// expire and query requests with one shared subtractor under a sequencer.
// ----------------------------------------------------------------------------
// Schedule forms the deadline (multiply, add), then scans past each entry due
// no later than the new one; cancel scans to the matching tag; query reads the
// head. Expire drops due entries in turn; schedule and expire walks use the
// single 48-bit subtractor. A new request is taken only in the idle state.
// Reset clears the entry count and the control state; the deadline and tag
// storage is not cleared and needs no clearing pass.
`default_nettype none

module sorted_timeout_queue_core
  import stq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire stq_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output stq_rsp_t      out_rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_SCAN,
    S_CSCAN,
    S_EXP,
    S_QUERY
  } state_e;

  state_e               state_q, state_d;
  stq_req_t             req_q, req_d;
  logic [DELAY_W-1:0]   delay_q, delay_d;
  logic [TIME_BITS-1:0] when_q, when_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [RES_W-1:0]     n_q, n_d;
  logic                 pend_q, pend_d;
  logic [TAG_W-1:0]     pend_tag_q, pend_tag_d;
  logic                 out_valid_q, out_valid_d;
  stq_rsp_t             out_q, out_d;

  logic [TIME_BITS-1:0] dl_q [DEPTH];
  logic [TAG_W-1:0]     tg_q [DEPTH];

  logic                 ins_en, drop_en;
  logic [IDX_W-1:0]     pos;
  logic [TIME_BITS-1:0] opa, opb;
  logic [TIME_BITS:0]   diff;
  logic                 le;
  logic [TIME_BITS:0]   sum;
  logic                 out_free;
  logic                 exp_due;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (state_q)
      S_SCAN: begin
        opa = dl_q[idx_q[IDX_W-1:0]];
        opb = when_q;
      end
      S_EXP: begin
        opa = dl_q[0];
        opb = req_q.now_us;
      end
      default: begin
        opa = req_q.now_us;
        opb = dl_q[0];
      end
    endcase
    diff = {1'b0, opb} - {1'b0, opa};
    le   = !diff[TIME_BITS];
  end

  assign sum     = {1'b0, req_q.now_us} + (TIME_BITS + 1)'(delay_q);
  assign exp_due = (n_q < RES_W'(MAX_RESULTS)) && (count_q != '0) && le;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    delay_d     = delay_q;
    when_d      = when_q;
    idx_d       = idx_q;
    count_d     = count_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_tag_d  = pend_tag_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ins_en      = 1'b0;
    drop_en     = 1'b0;
    pos         = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_req_i;
          idx_d  = '0;
          n_d    = '0;
          pend_d = 1'b0;
          unique case (in_req_i.mode)
            MODE_SCHEDULE: state_d = S_MUL;
            MODE_CANCEL:   state_d = S_CSCAN;
            MODE_EXPIRE:   state_d = S_EXP;
            MODE_QUERY:    state_d = S_QUERY;
          endcase
        end
      end
      S_MUL: begin
        delay_d = DELAY_W'(req_q.delay_s) * DELAY_W'(US_PER_S)
                + DELAY_W'(req_q.delay_us);
        state_d = S_ADD;
      end
      S_ADD: begin
        when_d  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (count_q == CNT_W'(DEPTH)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_d       = '{status: ST_FULL, out_tag: req_q.tag, wait_us: '0, last: 1'b1};
            state_d     = S_IDLE;
          end
        end else if (idx_q < count_q && le) begin
          idx_d = idx_q + 1'b1;
        end else if (out_free) begin
          ins_en      = 1'b1;
          count_d     = count_q + 1'b1;
          out_valid_d = 1'b1;
          out_d       = '{status: ST_SCHEDULED, out_tag: req_q.tag, wait_us: '0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_CSCAN: begin
        if (idx_q < count_q) begin
          if (tg_q[idx_q[IDX_W-1:0]] == req_q.tag) begin
            if (out_free) begin
              drop_en     = 1'b1;
              count_d     = count_q - 1'b1;
              out_valid_d = 1'b1;
              out_d       = '{status: ST_CANCELLED, out_tag: req_q.tag, wait_us: '0,
                              last: 1'b1};
              state_d     = S_IDLE;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: ST_NOT_FOUND, out_tag: req_q.tag, wait_us: '0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_EXP: begin
        if (exp_due) begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              out_valid_d = 1'b1;
              out_d       = '{status: ST_EXPIRED, out_tag: pend_tag_q, wait_us: '0,
                              last: 1'b0};
            end
            pend_d     = 1'b1;
            pend_tag_d = tg_q[0];
            drop_en    = 1'b1;
            pos        = '0;
            count_d    = count_q - 1'b1;
            n_d        = n_q + 1'b1;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          if (pend_q) begin
            out_d = '{status: ST_EXPIRED, out_tag: pend_tag_q, wait_us: '0, last: 1'b1};
          end else begin
            out_d = '{status: ST_NONE_DUE, out_tag: '0, wait_us: '0, last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end
      S_QUERY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_d = '{status: ST_EMPTY, out_tag: '0, wait_us: '0, last: 1'b1};
          end else begin
            out_d = '{status: ST_WAIT, out_tag: '0,
                      wait_us: diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0], last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      delay_q     <= '0;
      when_q      <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      pend_tag_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      delay_q     <= delay_d;
      when_q      <= when_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      pend_tag_q  <= pend_tag_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (IDX_W'(g) == pos) begin
          dl_q[g] <= when_q;
          tg_q[g] <= req_q.tag;
        end else if (IDX_W'(g) > pos) begin
          if (g > 0) begin
            dl_q[g] <= dl_q[(g > 0) ? g - 1 : 0];
            tg_q[g] <= tg_q[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (drop_en) begin
        if (IDX_W'(g) >= pos && g < DEPTH - 1) begin
          dl_q[g] <= dl_q[(g < DEPTH - 1) ? g + 1 : g];
          tg_q[g] <= tg_q[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

endmodule

`default_nettype wire
